>>> design/npc_pkg.sv
package npc_pkg;

  localparam logic [7:0] ChainStart = 8'hD5;
  localparam logic [7:0] HiNibMask  = 8'hF0;
  localparam logic [7:0] LoNibMask  = 8'h0F;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam int CfgIndexW = 3;
  localparam logic [CfgIndexW-1:0] CfgDecryptMode = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgMainKeyLow  = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgMainKeyHigh = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgPadKeyLow   = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgPadKeyHigh  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  typedef struct packed {
    logic         decrypt;
    logic         restart;
    logic [127:0] main_key;
    logic [127:0] pad_key;
  } cfg_t;

  // One unit of work for the back end: a completed pair or a lone last byte.
  typedef struct packed {
    logic       is_pair;
    logic [7:0] first;
    logic [7:0] second;
    logic [3:0] pos;
    logic       last;
  } job_t;

  function automatic logic [7:0] key_byte(logic [127:0] key, logic [3:0] p);
    return key[{p, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] nib_swap(logic [7:0] v);
    return {v[3:0], v[7:4]};
  endfunction

  function automatic logic [7:0] perm_fwd(logic [7:0] v);
    return {v[3], v[5], v[2], v[1], v[7], v[0], v[6], v[4]};
  endfunction

  function automatic logic [7:0] perm_inv(logic [7:0] v);
    return {v[3], v[1], v[6], v[0], v[7], v[5], v[4], v[2]};
  endfunction

endpackage

>>> design/npc_fifo.sv
module npc_fifo
  import npc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  localparam logic [QueuePtrW-1:0] PtrLast = QueuePtrW'(QueueDepth - 1);
  localparam logic [QueueCntW-1:0] CntFull = QueueCntW'(QueueDepth);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> design/npc_front.sv
module npc_front
  import npc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  input  in_word_t in_data_i,
  input  logic     queue_full_i,
  output logic     accept_o,
  output logic     push_o,
  output job_t     job_o
);

  logic [7:0] held_q, held_d;
  logic       held_valid_q, held_valid_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] chain_q, chain_d;
  logic [7:0] cur;
  logic       eom;

  assign eom      = in_data_i.end_of_message;
  assign accept_o = in_valid_i && !queue_full_i;
  assign push_o   = accept_o && (held_valid_q || eom);

  // Per-byte front stage; in decrypt mode the chain is the received word itself.
  always_comb begin
    if (cfg_i.decrypt) begin
      cur = perm_inv(in_data_i.data_byte ^ chain_q ^ key_byte(cfg_i.main_key, pos_q));
    end else begin
      cur = nib_swap(~in_data_i.data_byte) ^ key_byte(cfg_i.pad_key, pos_q);
    end
  end

  always_comb begin
    job_o.is_pair = held_valid_q;
    job_o.first   = held_q;
    job_o.second  = cur;
    job_o.pos     = pos_q;
    job_o.last    = eom;
  end

  always_comb begin
    held_d       = held_q;
    held_valid_d = held_valid_q;
    pos_d        = pos_q;
    chain_d      = chain_q;
    if (cfg_i.restart) begin
      held_valid_d = 1'b0;
      pos_d        = '0;
      chain_d      = ChainStart;
    end else if (accept_o) begin
      if (held_valid_q || eom) begin
        held_valid_d = 1'b0;
      end else begin
        held_d       = cur;
        held_valid_d = 1'b1;
      end
      pos_d = eom ? '0 : pos_q + 1'b1;
      if (eom) begin
        chain_d = ChainStart;
      end else if (cfg_i.decrypt) begin
        chain_d = in_data_i.data_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      pos_q        <= '0;
      chain_q      <= ChainStart;
    end else begin
      held_valid_q <= held_valid_d;
      pos_q        <= pos_d;
      chain_q      <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

>>> design/npc_back.sv
module npc_back
  import npc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic [7:0] chain_q, chain_d;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_q, out_d;
  logic       spare_valid_q, spare_valid_d;
  out_word_t  spare_q, spare_d;
  logic       out_free;
  logic [3:0] pos_p, pos_q_idx;
  logic [7:0] x, y, r0, r1;

  assign pos_p     = job_i.pos;
  assign pos_q_idx = job_i.pos - 1'b1;

  // r0 is the first result word of the job (the held byte, or the lone byte).
  always_comb begin
    x  = '0;
    y  = '0;
    r0 = '0;
    r1 = '0;
    if (cfg_i.decrypt) begin
      if (job_i.is_pair) begin
        x  = job_i.first ^ key_byte(cfg_i.pad_key, pos_q_idx);
        y  = job_i.second ^ key_byte(cfg_i.pad_key, pos_p);
        r0 = ~nib_swap(((x & HiNibMask) | (y & LoNibMask))
                       ^ key_byte(cfg_i.pad_key, pos_q_idx));
        r1 = ~nib_swap(((x & LoNibMask) | (y & HiNibMask))
                       ^ key_byte(cfg_i.pad_key, pos_p));
      end else begin
        r0 = ~nib_swap(job_i.second ^ key_byte(cfg_i.pad_key, pos_p));
      end
    end else begin
      if (job_i.is_pair) begin
        x  = ((job_i.first & HiNibMask) | (job_i.second & LoNibMask))
             ^ key_byte(cfg_i.pad_key, pos_q_idx);
        y  = ((job_i.first & LoNibMask) | (job_i.second & HiNibMask))
             ^ key_byte(cfg_i.pad_key, pos_p);
        r0 = perm_fwd(x) ^ key_byte(cfg_i.main_key, pos_q_idx) ^ chain_q;
        r1 = perm_fwd(y) ^ key_byte(cfg_i.main_key, pos_p) ^ r0;
      end else begin
        r0 = perm_fwd(job_i.second) ^ key_byte(cfg_i.main_key, pos_p) ^ chain_q;
      end
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = job_valid_i && out_free && !spare_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    spare_valid_d = spare_valid_q;
    spare_d       = spare_q;
    chain_d       = chain_q;
    if (spare_valid_q) begin
      if (out_free) begin
        out_d         = spare_q;
        out_valid_d   = 1'b1;
        spare_valid_d = 1'b0;
      end
    end else if (pop_o) begin
      out_valid_d      = 1'b1;
      out_d.out_byte   = r0;
      out_d.out_last   = job_i.is_pair ? 1'b0 : job_i.last;
      if (job_i.is_pair) begin
        spare_valid_d    = 1'b1;
        spare_d.out_byte = r1;
        spare_d.out_last = job_i.last;
      end
      if (!cfg_i.decrypt) begin
        chain_d = job_i.is_pair ? r1 : r0;
      end
      if (job_i.last) begin
        chain_d = ChainStart;
      end
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
    if (cfg_i.restart) begin
      chain_d = ChainStart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
      chain_q       <= ChainStart;
    end else begin
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
      chain_q       <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    spare_q <= spare_d;
  end

endmodule

>>> design/nibble_permute_chain_byte_cipher_unit.sv
// Byte-stream cipher with two 16-byte keys indexed by message position. One word
// is taken per cycle as long as the two-entry job queue has room; the front end
// applies the per-byte stage at once and holds the first byte of each pair until
// its partner or the end of the message arrives. The back end takes one job (a
// pair or a lone last byte) and delivers its words through an output register and
// a spare register, so the sustained rate is one word per cycle in both directions
// while the receiver does not stall. The first word of a job passes through the job
// queue and then the output register before it is on the output. Writing
// decrypt_mode restarts the message; key writes take effect for all stages not yet
// applied.
module nibble_permute_chain_byte_cipher_unit
  import npc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  logic        decrypt_q;
  logic [63:0] mk_lo_q, mk_hi_q, pk_lo_q, pk_hi_q;
  logic        cfg_wr;
  cfg_t        cfg;
  logic        queue_full, accept, push, pop, job_valid;
  job_t        push_job, pop_job;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
      mk_lo_q   <= '0;
      mk_hi_q   <= '0;
      pk_lo_q   <= '0;
      pk_hi_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CfgDecryptMode: decrypt_q <= cfg_data_i[0];
        CfgMainKeyLow:  mk_lo_q   <= cfg_data_i;
        CfgMainKeyHigh: mk_hi_q   <= cfg_data_i;
        CfgPadKeyLow:   pk_lo_q   <= cfg_data_i;
        CfgPadKeyHigh:  pk_hi_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The restart pulse comes with the mode write; the new mode is registered and seen in the following cycle.
  always_comb begin
    cfg.decrypt  = decrypt_q;
    cfg.restart  = cfg_wr && (cfg_index_i == CfgDecryptMode);
    cfg.main_key = {mk_hi_q, mk_lo_q};
    cfg.pad_key  = {pk_hi_q, pk_lo_q};
  end

  assign in_stall_o = queue_full;

  npc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .accept_o     (accept),
    .push_o       (push),
    .job_o        (push_job)
  );

  npc_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && accept),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (queue_full),
    .valid_o (job_valid),
    .job_o   (pop_job)
  );

  npc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/tb_top.sv
module tb_top
  import npc_pkg::*;
();

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 300;
  localparam int PhaseWords  = 145;
  localparam int Phases      = 7;
  localparam logic [CfgIndexW-1:0] CfgFirstUnused = CfgPadKeyHigh + 1'b1;
  localparam logic [CfgIndexW-1:0] CfgLastIndex   = '1;
  // Source bit of each output bit of the forward bit shuffle, output bit 7 on top.
  localparam logic [23:0] PermSrc = {3'd3, 3'd5, 3'd2, 3'd1, 3'd7, 3'd0, 3'd6, 3'd4};

  class cipher_stream_model;
    logic         decrypt;
    logic [127:0] main_key;
    logic [127:0] pad_key;
    logic [7:0]   held;
    bit           held_v;
    logic [3:0]   pos;
    logic [7:0]   chain;
    out_word_t    pending_bytes[$];
    int           mismatches;

    function new();
      decrypt    = 1'b0;
      main_key   = '0;
      pad_key    = '0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      held   = '0;
      held_v = 1'b0;
      pos    = '0;
      chain  = ChainStart;
    endfunction

    function logic [7:0] key_at(logic [127:0] k, logic [3:0] p);
      logic [127:0] s;
      s = k >> {p, 3'b000};
      return s[7:0];
    endfunction

    function logic [7:0] swap_halves(logic [7:0] v);
      logic [15:0] d;
      d = {v, v};
      return d[11:4];
    endfunction

    function logic [7:0] shuffle(logic [7:0] v, bit undo);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
        if (undo) r[PermSrc[3*i +: 3]] = v[i];
        else r[i] = v[PermSrc[3*i +: 3]];
      end
      return r;
    endfunction

    // Back stages of encryption: shuffle, main key, then chaining.
    function logic [7:0] seal(logic [7:0] v, logic [3:0] p);
      logic [7:0] c;
      c = shuffle(v, 1'b0) ^ key_at(main_key, p) ^ chain;
      chain = c;
      return c;
    endfunction

    function logic [7:0] unwrap(logic [7:0] v, logic [3:0] p);
      return ~swap_halves(v ^ key_at(pad_key, p));
    endfunction

    function void push(logic [7:0] b, logic l);
      out_word_t w;
      w.out_byte = b;
      w.out_last = l;
      pending_bytes.push_back(w);
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [63:0] val);
      case (idx)
        CfgDecryptMode: begin
          decrypt = val[0];
          restart();
        end
        CfgMainKeyLow:  main_key[63:0]   = val;
        CfgMainKeyHigh: main_key[127:64] = val;
        CfgPadKeyLow:   pad_key[63:0]    = val;
        CfgPadKeyHigh:  pad_key[127:64]  = val;
        default: ;
      endcase
    endfunction

    function void take_byte(in_word_t w);
      logic [7:0] cur, x, y;
      logic [3:0] p, q;
      p = pos;
      q = pos - 4'd1;
      if (decrypt) begin
        x = w.data_byte ^ chain;
        chain = w.data_byte;
        cur = shuffle(x ^ key_at(main_key, p), 1'b1);
      end else begin
        cur = swap_halves(~w.data_byte) ^ key_at(pad_key, p);
      end
      if (held_v) begin
        if (decrypt) begin
          x = held ^ key_at(pad_key, q);
          y = cur ^ key_at(pad_key, p);
          push(unwrap({x[7:4], y[3:0]}, q), 1'b0);
          push(unwrap({y[7:4], x[3:0]}, p), w.end_of_message);
        end else begin
          x = {held[7:4], cur[3:0]} ^ key_at(pad_key, q);
          y = {cur[7:4], held[3:0]} ^ key_at(pad_key, p);
          push(seal(x, q), 1'b0);
          push(seal(y, p), w.end_of_message);
        end
        held_v = 1'b0;
        held   = '0;
      end else if (w.end_of_message) begin
        push(decrypt ? unwrap(cur, p) : seal(cur, p), 1'b1);
      end else begin
        held   = cur;
        held_v = 1'b1;
      end
      if (w.end_of_message) restart();
      else pos = p + 4'd1;
    endfunction

    task report(string what);
      if (mismatches < 100) $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task match_byte(out_word_t got);
      out_word_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected output word byte=%h last=%b", got.out_byte, got.out_last));
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte got %h, expected %h", got.out_byte, want.out_byte));
        if (got.out_last !== want.out_last)
          report($sformatf("out_last got %b, expected %b", got.out_last, want.out_last));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_word_t             in_word;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_word_t            out_word;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [63:0]          cfg_data_i;

  cipher_stream_model sb = new();

  int  cycle_count = 0;
  int  words_sent  = 0;
  int  messages    = 0;
  int  words_out   = 0;
  int  reg_writes  = 0;
  int  rx_busy_pct = 20;
  int  tx_gap_pct  = 20;
  bit  hold_req    = 1'b0;

  nibble_permute_chain_byte_cipher_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               sb.pending_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Monitors sample the handshakes at the edge, before any nonblocking update lands.
  always @(posedge clk) begin
    if (rst_n && in_valid_i && !in_stall_o) sb.take_byte(in_word);
    if (rst_n && cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
    if (rst_n && out_valid_o && !out_stall_i) begin
      words_out++;
      sb.match_byte(out_word);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else if ($urandom_range(99) < rx_busy_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(18, 1)) @(posedge clk);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    return ($urandom_range(99) < tx_gap_pct) ? $urandom_range(18, 1) : 0;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [7:0] b, logic eom, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_word <= '{data_byte: b, end_of_message: eom};
    do @(posedge clk); while (in_stall_o);
    words_sent++;
    if (eom) messages++;
  endtask

  // Stop sending and let every expected word come out, then wait DrainCycles more
  // edges so that a held first byte has settled before a register changes. The first
  // edge lets the monitor note the last accepted word before the count is looked at.
  task automatic drain_stream();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [63:0] val, bit more);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    if (!more) cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_some_key();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(4))
      0: cfg_write(CfgMainKeyLow, v, 1'b0);
      1: cfg_write(CfgMainKeyHigh, v, 1'b0);
      2: cfg_write(CfgPadKeyLow, v, 1'b0);
      3: cfg_write(CfgPadKeyHigh, v, 1'b0);
      default: cfg_write(CfgIndexW'($urandom_range(CfgLastIndex, CfgFirstUnused)), v, 1'b0);
    endcase
  endtask

  task automatic configure(int ph);
    logic [63:0] kv[4];
    logic [63:0] mode;
    mode = {$urandom, $urandom};
    mode[0] = (ph == Phases - 1) ? 1'($urandom_range(1)) : ph[0];
    for (int i = 0; i < 4; i++) begin
      case (ph)
        1: kv[i] = '1;
        3: kv[i] = '0;
        default: kv[i] = {$urandom, $urandom};
      endcase
    end
    cfg_write(CfgDecryptMode, mode, 1'b1);
    cfg_write(CfgMainKeyLow, kv[0], 1'b1);
    cfg_write(CfgMainKeyHigh, kv[1], 1'b1);
    cfg_write(CfgPadKeyLow, kv[2], 1'b1);
    cfg_write(CfgPadKeyHigh, kv[3], 1'b0);
  endtask

  initial begin
    int len;
    int cut;
    int phase_start;
    rst_n       <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgDecryptMode;
    cfg_data_i  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lone bytes, pairs, extreme keys, key change and abort mid-message.
    send_word(8'h00, 1'b1, 0);
    send_word(8'hFF, 1'b0, 0);
    send_word(8'h00, 1'b1, 0);
    drain_stream();
    cfg_write(CfgMainKeyLow, '1, 1'b1);
    cfg_write(CfgMainKeyHigh, '1, 1'b1);
    cfg_write(CfgPadKeyLow, '1, 1'b1);
    cfg_write(CfgPadKeyHigh, '1, 1'b0);
    send_word(8'hA5, 1'b0, 0);
    send_word(8'h5A, 1'b0, 2);
    send_word(8'hFF, 1'b1, 0);
    send_word(8'h3C, 1'b0, 0);
    drain_stream();
    cfg_write(CfgMainKeyLow, {$urandom, $urandom}, 1'b1);
    cfg_write(CfgPadKeyLow, {$urandom, $urandom}, 1'b0);
    send_word(8'hC3, 1'b1, 0);
    send_word(8'h11, 1'b0, 0);
    drain_stream();
    // A mode write drops the held first byte.
    cfg_write(CfgDecryptMode, 64'd1, 1'b0);
    send_word(8'h00, 1'b0, 0);
    send_word(8'hFF, 1'b1, 0);
    send_word(8'h7E, 1'b1, 1);
    drain_stream();
    cfg_write(CfgFirstUnused, {$urandom, $urandom}, 1'b1);
    cfg_write(CfgLastIndex, {$urandom, $urandom}, 1'b0);
    send_word(8'h12, 1'b0, 0);
    send_word(8'h34, 1'b1, 0);

    for (int ph = 0; ph < Phases; ph++) begin
      drain_stream();
      configure(ph);
      if (ph == Phases - 1) begin
        rx_busy_pct = 0;
        tx_gap_pct  = 0;
      end else begin
        rx_busy_pct = (ph == 4) ? 0 : $urandom_range(40, 5);
        tx_gap_pct  = (ph == 2 || ph == 5) ? 0 : $urandom_range(40, 5);
      end
      if (ph == 2) hold_req = 1'b1;
      phase_start = words_sent;
      while (words_sent - phase_start < PhaseWords) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(8, 1);
        cut = (len > 1 && $urandom_range(9) == 0) ? $urandom_range(len - 1, 1) : 0;
        for (int i = 0; i < len; i++) begin
          if (cut != 0 && i == cut) begin
            drain_stream();
            if ($urandom_range(1)) begin
              write_some_key();
            end else begin
              cfg_write(CfgDecryptMode, {$urandom, $urandom}, 1'b0);
              break;
            end
          end
          send_word(rand_byte(), i == len - 1, pick_gap());
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d input words in %0d messages and %0d checked output words,",
             words_sent, messages, words_out);
    $display("with %0d register writes across both modes and all key extremes.", reg_writes);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
